@@ hdl/cra_pkg.sv @@
// shared types and constants for the contiguous region allocator
`default_nettype none
package cra_pkg;

  localparam int AddrW         = 21;
  localparam int OwnerW        = 32;
  localparam int MaxRegionsDef = 32;
  localparam int MaxReport     = 32;

  localparam logic [AddrW-1:0] TotalReset = AddrW'(1048576);

  typedef enum logic [1:0] {
    CmdRequest = 2'd0,
    CmdRelease = 2'd1,
    CmdCompact = 2'd2,
    CmdReport  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StNoHole = 2'd1,
    StFull   = 2'd2,
    StReport = 2'd3
  } status_e;

  localparam logic [1:0] StratFirst = 2'd0;
  localparam logic [1:0] StratBest  = 2'd1;
  localparam logic [1:0] StratWorst = 2'd2;

  typedef struct packed {
    logic [AddrW-1:0]  lo;
    logic [AddrW-1:0]  hi;
    logic [OwnerW-1:0] owner;
    logic              free;
  } entry_t;

  typedef struct packed {
    status_e           status;
    logic [AddrW-1:0]  lo;
    logic [AddrW-1:0]  hi;
    logic [OwnerW-1:0] owner;
    logic              free;
    logic              last;
  } result_t;

endpackage
`default_nettype wire

@@ hdl/cra_table.sv @@
// region table memory with one write and one registered read port
`default_nettype none
module cra_table #(
  parameter int MaxRegions = cra_pkg::MaxRegionsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          init_i,
  input  wire logic [cra_pkg::AddrW-1:0]     total_i,
  input  wire logic                          rd_en_i,
  input  wire logic [$clog2(MaxRegions)-1:0] rd_addr_i,
  output cra_pkg::entry_t                    rd_data_o,
  input  wire logic                          wr_en_i,
  input  wire logic [$clog2(MaxRegions)-1:0] wr_addr_i,
  input  cra_pkg::entry_t                    wr_data_i
);
  import cra_pkg::*;

  entry_t mem [MaxRegions];
  entry_t ram_q;
  logic   pristine_q;
  logic   hit_q;
  entry_t init_entry;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      ram_q <= mem[rd_addr_i];
    end
  end

  // entry zero reads as the whole memory, free, after reset or init until it is next written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pristine_q <= 1'b1;
      hit_q      <= 1'b0;
    end else begin
      if (init_i) begin
        pristine_q <= 1'b1;
      end else if (wr_en_i && wr_addr_i == '0) begin
        pristine_q <= 1'b0;
      end
      if (rd_en_i) begin
        hit_q <= pristine_q && rd_addr_i == '0;
      end
    end
  end

  always_comb begin
    init_entry.lo    = '0;
    init_entry.hi    = total_i;
    init_entry.owner = '0;
    init_entry.free  = 1'b1;
    rd_data_o        = hit_q ? init_entry : ram_q;
  end

endmodule
`default_nettype wire

@@ hdl/cra_ctrl.sv @@
// command sequencer: scans, rewrites and reports the region table
`default_nettype none
module cra_ctrl #(
  parameter int MaxRegions = cra_pkg::MaxRegionsDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  input  wire logic [1:0]                      command_i,
  input  wire logic [cra_pkg::OwnerW-1:0]      owner_id_i,
  input  wire logic [cra_pkg::AddrW-1:0]       amount_i,
  input  wire logic [1:0]                      strategy_i,
  input  wire logic                            cfg_init_i,
  output logic                                 idle_o,
  output logic [$clog2(MaxRegions+1)-1:0]      count_o,
  output logic                                 rd_en_o,
  output logic [$clog2(MaxRegions)-1:0]        rd_addr_o,
  input  cra_pkg::entry_t                      rd_data_i,
  output logic                                 wr_en_o,
  output logic [$clog2(MaxRegions)-1:0]        wr_addr_o,
  output cra_pkg::entry_t                      wr_data_o,
  output logic                                 res_valid_o,
  output cra_pkg::result_t                     res_o,
  input  wire logic                            res_ready_i
);
  import cra_pkg::*;

  localparam int IdxW = $clog2(MaxRegions);
  localparam int CntW = $clog2(MaxRegions+1);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_FIN, S_SHIFT, S_SPLIT1, S_SPLIT2, S_RES,
    S_RPT_RD, S_RPT_WAIT, S_RPT_OUT
  } state_e;

  state_e            state_q, state_d;
  cmd_e              cmd_q, cmd_d;
  logic [OwnerW-1:0] owner_q, owner_d;
  logic [AddrW-1:0]  amt_q, amt_d;
  logic [1:0]        strat_q, strat_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   ri_q, ri_d;
  logic [IdxW-1:0]   rix_q, rix_d;
  logic              rv_q, rv_d;
  logic [CntW-1:0]   wi_q, wi_d;
  logic              found_q, found_d;
  logic [IdxW-1:0]   ch_idx_q, ch_idx_d;
  logic [AddrW-1:0]  ch_len_q, ch_len_d;
  logic [AddrW-1:0]  ch_lo_q, ch_lo_d;
  logic [AddrW-1:0]  ch_hi_q, ch_hi_d;
  entry_t            acc_q, acc_d;
  logic              acc_v_q, acc_v_d;
  logic [AddrW-1:0]  pos_q, pos_d;
  logic [AddrW-1:0]  fsum_q, fsum_d;
  result_t           res_q, res_d;
  logic              res_v_q, res_v_d;

  entry_t            e;
  entry_t            ef;
  logic [AddrW-1:0]  len;
  logic              issue;
  logic [CntW-1:0]   rpt_n;
  logic [CntW-1:0]   ri_dec;

  assign idle_o      = state_q == S_IDLE;
  assign count_o     = count_q;
  assign res_valid_o = res_v_q;
  assign res_o       = res_q;

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    owner_d  = owner_q;
    amt_d    = amt_q;
    strat_d  = strat_q;
    count_d  = count_q;
    ri_d     = ri_q;
    rix_d    = rix_q;
    rv_d     = 1'b0;
    wi_d     = wi_q;
    found_d  = found_q;
    ch_idx_d = ch_idx_q;
    ch_len_d = ch_len_q;
    ch_lo_d  = ch_lo_q;
    ch_hi_d  = ch_hi_q;
    acc_d    = acc_q;
    acc_v_d  = acc_v_q;
    pos_d    = pos_q;
    fsum_d   = fsum_q;
    res_d    = res_q;
    res_v_d  = res_v_q;

    rd_en_o   = 1'b0;
    rd_addr_o = ri_q[IdxW-1:0];
    wr_en_o   = 1'b0;
    wr_addr_o = wi_q[IdxW-1:0];
    wr_data_o = '0;
    issue     = 1'b0;
    ri_dec    = ri_q - CntW'(1);

    e   = rd_data_i;
    len = e.hi - e.lo;
    ef  = e;
    if (!e.free && e.owner == owner_q) begin
      ef.free  = 1'b1;
      ef.owner = '0;
    end
    rpt_n = (int'(count_q) > MaxReport) ? CntW'(MaxReport) : count_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = cmd_e'(command_i);
          owner_d = owner_id_i;
          amt_d   = amount_i;
          strat_d = strategy_i;
          ri_d    = '0;
          wi_d    = '0;
          found_d = 1'b0;
          acc_v_d = 1'b0;
          pos_d   = '0;
          fsum_d  = '0;
          res_d   = '0;
          case (cmd_e'(command_i))
            CmdRequest: begin
              if (amount_i == '0 || (strategy_i != StratFirst &&
                  strategy_i != StratBest && strategy_i != StratWorst)) begin
                res_d.status = StNoHole;
                res_d.last   = 1'b1;
                res_v_d      = 1'b1;
                state_d      = S_RES;
              end else begin
                state_d = S_SCAN;
              end
            end
            CmdRelease, CmdCompact: state_d = S_SCAN;
            CmdReport:              state_d = S_RPT_RD;
            default:                state_d = S_IDLE;
          endcase
        end
      end

      S_SCAN: begin
        issue = ri_q < count_q;
        if (issue) begin
          rd_en_o = 1'b1;
          rix_d   = ri_q[IdxW-1:0];
          ri_d    = ri_q + CntW'(1);
        end
        rv_d = issue;
        if (rv_q) begin
          case (cmd_q)
            CmdRequest: begin
              if (e.free && len >= amt_q && (!found_q ||
                  (strat_q == StratBest && len < ch_len_q) ||
                  (strat_q == StratWorst && len > ch_len_q))) begin
                found_d  = 1'b1;
                ch_idx_d = rix_q;
                ch_len_d = len;
                ch_lo_d  = e.lo;
                ch_hi_d  = e.hi;
              end
            end
            CmdRelease: begin
              // a held entry absorbs following free neighbors before write-back
              if (acc_v_q && acc_q.free && ef.free) begin
                acc_d.hi = ef.hi;
              end else begin
                if (acc_v_q) begin
                  wr_en_o   = 1'b1;
                  wr_addr_o = wi_q[IdxW-1:0];
                  wr_data_o = acc_q;
                  wi_d      = wi_q + CntW'(1);
                end
                acc_d   = ef;
                acc_v_d = 1'b1;
              end
            end
            CmdCompact: begin
              if (e.free) begin
                fsum_d = fsum_q + len;
              end else begin
                wr_en_o         = 1'b1;
                wr_addr_o       = wi_q[IdxW-1:0];
                wr_data_o.lo    = pos_q;
                wr_data_o.hi    = pos_q + len;
                wr_data_o.owner = e.owner;
                wr_data_o.free  = 1'b0;
                wi_d            = wi_q + CntW'(1);
                pos_d           = pos_q + len;
              end
            end
            default: ;
          endcase
        end
        if (!issue && !rv_q) begin
          state_d = S_FIN;
        end
      end

      S_FIN: begin
        res_d      = '0;
        res_d.last = 1'b1;
        res_v_d    = 1'b1;
        state_d    = S_RES;
        case (cmd_q)
          CmdRequest: begin
            if (!found_q) begin
              res_d.status = StNoHole;
            end else if (ch_len_q == amt_q) begin
              wr_en_o         = 1'b1;
              wr_addr_o       = ch_idx_q;
              wr_data_o.lo    = ch_lo_q;
              wr_data_o.hi    = ch_lo_q + amt_q;
              wr_data_o.owner = owner_q;
              wr_data_o.free  = 1'b0;
              res_d.status    = StOk;
              res_d.lo        = ch_lo_q;
              res_d.hi        = ch_lo_q + amt_q;
              res_d.owner     = owner_q;
            end else if (count_q >= CntW'(MaxRegions)) begin
              res_d.status = StFull;
            end else begin
              res_v_d = 1'b0;
              ri_d    = count_q;
              state_d = S_SHIFT;
            end
          end
          CmdRelease: begin
            wr_en_o   = 1'b1;
            wr_addr_o = wi_q[IdxW-1:0];
            wr_data_o = acc_q;
            count_d   = wi_q + CntW'(1);
          end
          CmdCompact: begin
            if ((fsum_q != '0 || wi_q == '0) && wi_q < CntW'(MaxRegions)) begin
              wr_en_o         = 1'b1;
              wr_addr_o       = wi_q[IdxW-1:0];
              wr_data_o.lo    = pos_q;
              wr_data_o.hi    = pos_q + fsum_q;
              wr_data_o.owner = '0;
              wr_data_o.free  = 1'b1;
              count_d         = wi_q + CntW'(1);
            end else begin
              count_d = wi_q;
            end
          end
          default: ;
        endcase
      end

      S_SHIFT: begin
        // move entries above the chosen hole up by one, top first
        issue = ri_q > (CntW'(ch_idx_q) + CntW'(1));
        if (issue) begin
          rd_en_o   = 1'b1;
          rd_addr_o = ri_dec[IdxW-1:0];
          rix_d     = ri_dec[IdxW-1:0];
          ri_d      = ri_dec;
        end
        rv_d = issue;
        if (rv_q) begin
          wr_en_o   = 1'b1;
          wr_addr_o = rix_q + IdxW'(1);
          wr_data_o = e;
        end
        if (!issue && !rv_q) begin
          state_d = S_SPLIT1;
        end
      end

      S_SPLIT1: begin
        wr_en_o         = 1'b1;
        wr_addr_o       = ch_idx_q + IdxW'(1);
        wr_data_o.lo    = ch_lo_q + amt_q;
        wr_data_o.hi    = ch_hi_q;
        wr_data_o.owner = '0;
        wr_data_o.free  = 1'b1;
        state_d         = S_SPLIT2;
      end

      S_SPLIT2: begin
        wr_en_o         = 1'b1;
        wr_addr_o       = ch_idx_q;
        wr_data_o.lo    = ch_lo_q;
        wr_data_o.hi    = ch_lo_q + amt_q;
        wr_data_o.owner = owner_q;
        wr_data_o.free  = 1'b0;
        count_d         = count_q + CntW'(1);
        res_d.status    = StOk;
        res_d.lo        = ch_lo_q;
        res_d.hi        = ch_lo_q + amt_q;
        res_d.owner     = owner_q;
        res_d.free      = 1'b0;
        res_d.last      = 1'b1;
        res_v_d         = 1'b1;
        state_d         = S_RES;
      end

      S_RES: begin
        if (res_ready_i) begin
          res_v_d = 1'b0;
          state_d = S_IDLE;
        end
      end

      S_RPT_RD: begin
        rd_en_o = 1'b1;
        ri_d    = ri_q + CntW'(1);
        state_d = S_RPT_WAIT;
      end

      S_RPT_WAIT: begin
        res_d.status = StReport;
        res_d.lo     = e.lo;
        res_d.hi     = e.hi;
        res_d.owner  = e.free ? '0 : e.owner;
        res_d.free   = e.free;
        res_d.last   = ri_q == rpt_n;
        res_v_d      = 1'b1;
        state_d      = S_RPT_OUT;
      end

      S_RPT_OUT: begin
        if (res_ready_i) begin
          res_v_d = 1'b0;
          state_d = res_q.last ? S_IDLE : S_RPT_RD;
        end
      end

      default: state_d = S_IDLE;
    endcase

    if (cfg_init_i) begin
      count_d = CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= CntW'(1);
      rv_q    <= 1'b0;
      res_v_q <= 1'b0;
      found_q <= 1'b0;
      acc_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rv_q    <= rv_d;
      res_v_q <= res_v_d;
      found_q <= found_d;
      acc_v_q <= acc_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    owner_q  <= owner_d;
    amt_q    <= amt_d;
    strat_q  <= strat_d;
    ri_q     <= ri_d;
    rix_q    <= rix_d;
    wi_q     <= wi_d;
    ch_idx_q <= ch_idx_d;
    ch_len_q <= ch_len_d;
    ch_lo_q  <= ch_lo_d;
    ch_hi_q  <= ch_hi_d;
    acc_q    <= acc_d;
    pos_q    <= pos_d;
    fsum_q   <= fsum_d;
    res_q    <= res_d;
  end

endmodule
`default_nettype wire

@@ hdl/contiguous_region_allocator.sv @@
// contiguous region allocator top level: config register, output register, table, sequencer
//
//   channel  direction  handshake                  transaction payload
//   in       input      in_valid_i / in_stall_o    command, owner_id, amount, strategy
//   out      output     out_valid_o / out_stall_i  status, region bounds, owner, free, last
//   cfg      input      cfg_valid_i / cfg_ready_o  total_size
//
// one command at a time; release, compact and a valid request scan the table through its single
// read port, and a split request also shifts the entries above the chosen hole up by one.
// a report reads each region in turn, then presents it and waits out any output stall.
// after reset the table holds one free region [0, 1048576); a config write reloads it.
// a result waits in the output register while the next command is taken.
`default_nettype none
module contiguous_region_allocator #(
  parameter int MaxRegions = cra_pkg::MaxRegionsDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [1:0]                 command_i,
  input  wire logic [cra_pkg::OwnerW-1:0] owner_id_i,
  input  wire logic [cra_pkg::AddrW-1:0]  amount_i,
  input  wire logic [1:0]                 strategy_i,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [cra_pkg::AddrW-1:0]  total_size_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [1:0]                      status_o,
  output logic [cra_pkg::AddrW-1:0]       region_start_o,
  output logic [cra_pkg::AddrW-1:0]       region_end_o,
  output logic [cra_pkg::OwnerW-1:0]      region_owner_o,
  output logic                            region_free_o,
  output logic                            last_o
);
  import cra_pkg::*;

  localparam int IdxW = $clog2(MaxRegions);
  localparam int CntW = $clog2(MaxRegions+1);

  logic [AddrW-1:0] total_q;
  result_t          out_q;
  logic             out_v_q;
  logic             cfg_fire;
  logic             idle;
  logic [CntW-1:0]  count;
  logic             rd_en;
  logic [IdxW-1:0]  rd_addr;
  entry_t           rd_data;
  logic             wr_en;
  logic [IdxW-1:0]  wr_addr;
  entry_t           wr_data;
  logic             res_valid;
  result_t          res;
  logic             res_ready;

  assign in_stall_o  = !idle;
  // a command offered in the same cycle goes first
  assign cfg_ready_o = idle && !in_valid_i;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign res_ready   = !out_v_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TotalReset;
      out_v_q <= 1'b0;
    end else begin
      if (cfg_fire) begin
        total_q <= total_size_i;
      end
      if (res_valid && res_ready) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_v_q;
  assign status_o       = out_q.status;
  assign region_start_o = out_q.lo;
  assign region_end_o   = out_q.hi;
  assign region_owner_o = out_q.owner;
  assign region_free_o  = out_q.free;
  assign last_o         = out_q.last;

  cra_table #(.MaxRegions(MaxRegions)) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .init_i    (cfg_fire),
    .total_i   (total_q),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  cra_ctrl #(.MaxRegions(MaxRegions)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .command_i   (command_i),
    .owner_id_i  (owner_id_i),
    .amount_i    (amount_i),
    .strategy_i  (strategy_i),
    .cfg_init_i  (cfg_fire),
    .idle_o      (idle),
    .count_o     (count),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count != '0 && count <= CntW'(MaxRegions))
    else $error("region count out of range");

  a_idle_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idle |-> !res_valid)
    else $error("result pending while sequencer idle");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != StReport |-> last_o)
    else $error("command result without last");
`endif

endmodule
`default_nettype wire

@@ test/region_checker.sv @@
// checker for the region allocator: predicts the region table and compares every result
module region_checker (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  input  wire logic                       in_stall_i,
  input  wire logic [1:0]                 command_i,
  input  wire logic [cra_pkg::OwnerW-1:0] owner_id_i,
  input  wire logic [cra_pkg::AddrW-1:0]  amount_i,
  input  wire logic [1:0]                 strategy_i,
  input  wire logic                       cfg_valid_i,
  input  wire logic                       cfg_ready_i,
  input  wire logic [cra_pkg::AddrW-1:0]  total_size_i,
  input  wire logic                       out_valid_i,
  input  wire logic                       out_stall_i,
  input  wire logic [1:0]                 status_i,
  input  wire logic [cra_pkg::AddrW-1:0]  region_start_i,
  input  wire logic [cra_pkg::AddrW-1:0]  region_end_i,
  input  wire logic [cra_pkg::OwnerW-1:0] region_owner_i,
  input  wire logic                       region_free_i,
  input  wire logic                       last_i,
  output int                              fail_count_o,
  output int                              pending_o
);
  import cra_pkg::*;

  localparam int Slots = MaxRegionsDef;

  entry_t    tbl[Slots];
  int        used;
  result_t   owed[$];

  assign pending_o = owed.size();

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    fail_count_o++;
  endtask

  function automatic result_t mk(status_e st, logic [AddrW-1:0] lo, logic [AddrW-1:0] hi,
                                 logic [OwnerW-1:0] own, logic fr, logic lst);
    result_t r;
    r.status = st; r.lo = lo; r.hi = hi; r.owner = own; r.free = fr; r.last = lst;
    return r;
  endfunction

  function automatic void load_table(logic [AddrW-1:0] total);
    for (int i = 0; i < Slots; i++) tbl[i] = '0;
    tbl[0].hi = total;
    tbl[0].free = 1'b1;
    used = 1;
  endfunction

  function automatic void grant(logic [OwnerW-1:0] own, logic [AddrW-1:0] amt,
                                logic [1:0] strat);
    int pick;
    logic [AddrW-1:0] plen, len, base;
    pick = -1;
    plen = '0;
    for (int i = 0; i < used; i++) begin
      len = tbl[i].hi - tbl[i].lo;
      if (!tbl[i].free || len < amt) continue;
      if (strat == StratFirst) begin
        pick = i; plen = len; break;
      end
      if ((strat == StratBest && (pick < 0 || len < plen)) ||
          (strat == StratWorst && (pick < 0 || len > plen))) begin
        pick = i; plen = len;
      end
    end
    if (amt == 0 || strat > StratWorst || pick < 0) begin
      owed.push_back(mk(StNoHole, '0, '0, '0, 1'b0, 1'b1));
      return;
    end
    base = tbl[pick].lo;
    if (plen != amt) begin
      if (used >= Slots) begin
        owed.push_back(mk(StFull, '0, '0, '0, 1'b0, 1'b1));
        return;
      end
      for (int i = used; i > pick + 1; i--) tbl[i] = tbl[i-1];
      tbl[pick+1].lo = base + amt;
      tbl[pick+1].hi = tbl[pick].hi;
      tbl[pick+1].owner = '0;
      tbl[pick+1].free = 1'b1;
      tbl[pick].hi = base + amt;
      used++;
    end
    tbl[pick].owner = own;
    tbl[pick].free = 1'b0;
    owed.push_back(mk(StOk, base, base + amt, own, 1'b0, 1'b1));
  endfunction

  function automatic void free_owner(logic [OwnerW-1:0] own);
    int w;
    w = 0;
    for (int r = 0; r < used; r++)
      if (!tbl[r].free && tbl[r].owner == own) begin
        tbl[r].free = 1'b1;
        tbl[r].owner = '0;
      end
    for (int r = 0; r < used; r++) begin
      if (w > 0 && tbl[w-1].free && tbl[r].free) tbl[w-1].hi = tbl[r].hi;
      else begin
        tbl[w] = tbl[r];
        w++;
      end
    end
    used = w;
  endfunction

  function automatic void slide_down();
    int w;
    logic [AddrW-1:0] pos, spare, len;
    w = 0; pos = '0; spare = '0;
    for (int r = 0; r < used; r++) begin
      len = tbl[r].hi - tbl[r].lo;
      if (tbl[r].free) spare += len;
      else begin
        tbl[w].lo = pos;
        tbl[w].hi = pos + len;
        tbl[w].owner = tbl[r].owner;
        tbl[w].free = 1'b0;
        pos += len;
        w++;
      end
    end
    if ((spare > 0 || w == 0) && w < Slots) begin
      tbl[w].lo = pos;
      tbl[w].hi = pos + spare;
      tbl[w].owner = '0;
      tbl[w].free = 1'b1;
      w++;
    end
    used = w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got, exp;
    if (!rst_ni) begin
      load_table(TotalReset);
      owed.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) load_table(total_size_i);
      if (in_valid_i && !in_stall_i) begin
        case (cmd_e'(command_i))
          CmdRequest: grant(owner_id_i, amount_i, strategy_i);
          CmdRelease: begin
            free_owner(owner_id_i);
            owed.push_back(mk(StOk, '0, '0, '0, 1'b0, 1'b1));
          end
          CmdCompact: begin
            slide_down();
            owed.push_back(mk(StOk, '0, '0, '0, 1'b0, 1'b1));
          end
          default: begin
            for (int i = 0; i < used && i < MaxReport; i++)
              owed.push_back(mk(StReport, tbl[i].lo, tbl[i].hi,
                                tbl[i].free ? '0 : tbl[i].owner, tbl[i].free,
                                (i + 1 == used || i + 1 == MaxReport)));
          end
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        got = mk(status_e'(status_i), region_start_i, region_end_i, region_owner_i,
                 region_free_i, last_i);
        if (owed.size() == 0) report_mismatch("result with nothing expected");
        else begin
          exp = owed.pop_front();
          if (got != exp)
            report_mismatch($sformatf("got st%0d [%0d,%0d) own %h f%0d l%0d, want st%0d [%0d,%0d) own %h f%0d l%0d",
              got.status, got.lo, got.hi, got.owner, got.free, got.last,
              exp.status, exp.lo, exp.hi, exp.owner, exp.free, exp.last));
        end
      end
    end
  end
endmodule

@@ test/tb.sv @@
// testbench top: clock, reset, stimulus, configuration phases and verdict
module tb;
  import cra_pkg::*;

  logic clk, rst_n;
  logic in_valid, in_stall, cfg_valid, cfg_ready, out_valid, out_stall;
  logic [1:0] command, strategy, status;
  logic [OwnerW-1:0] owner_id, region_owner;
  logic [AddrW-1:0] amount, total_size, region_start, region_end;
  logic region_free, last;
  int fails, pending;
  bit hold_long;

  logic [OwnerW-1:0] owners[4];
  logic [AddrW-1:0]  cur_total;

  contiguous_region_allocator dut (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_stall_o(in_stall),
    .command_i(command), .owner_id_i(owner_id), .amount_i(amount), .strategy_i(strategy),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .total_size_i(total_size),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .status_o(status),
    .region_start_o(region_start), .region_end_o(region_end),
    .region_owner_o(region_owner), .region_free_o(region_free), .last_o(last)
  );

  region_checker chk (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_stall_i(in_stall),
    .command_i(command), .owner_id_i(owner_id), .amount_i(amount), .strategy_i(strategy),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .total_size_i(total_size),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .status_i(status),
    .region_start_i(region_start), .region_end_i(region_end),
    .region_owner_i(region_owner), .region_free_i(region_free), .last_i(last),
    .fail_count_o(fails), .pending_o(pending)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver stalls at random, or holds off for a long stretch on request
  initial begin
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (600) @(posedge clk);
        hold_long = 0;
      end
      out_stall <= 1'b0;
      @(posedge clk);
      if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat (gap_len() + 1) @(posedge clk);
      end
    end
  end

  task automatic send(logic [1:0] cmd, logic [OwnerW-1:0] own, logic [AddrW-1:0] amt,
                      logic [1:0] strat, bit no_gap);
    command <= cmd; owner_id <= own; amount <= amt; strategy <= strat;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!no_gap) begin
      int g;
      g = gap_len();
      if (g > 0) begin
        in_valid <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_total(logic [AddrW-1:0] t);
    drain();
    total_size <= t;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_total = t;
    @(posedge clk);
  endtask

  // mostly real owners and sizes scaled to the memory, some noise
  task automatic random_item(bit no_gap);
    logic [1:0] cmd;
    logic [AddrW-1:0] amt;
    logic [OwnerW-1:0] own;
    logic [1:0] strat;
    int p;
    p = $urandom_range(0, 99);
    cmd = p < 60 ? CmdRequest : p < 80 ? CmdRelease : p < 88 ? CmdCompact : CmdReport;
    own = ($urandom_range(0, 9) == 0) ? $urandom() : owners[$urandom_range(0, 3)];
    case ($urandom_range(0, 5))
      0: amt = AddrW'($urandom_range(0, 3));
      1: amt = AddrW'($urandom());
      2: amt = cur_total;
      default: amt = AddrW'($urandom_range(1, (cur_total >> 3) + 1));
    endcase
    strat = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    send(cmd, own, amt, strat, no_gap);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0; cfg_valid = 1'b0; hold_long = 0;
    command = '0; owner_id = '0; amount = '0; strategy = '0; total_size = '0;
    cur_total = TotalReset;
    owners[0] = 32'h0000_0001; owners[1] = 32'hFFFF_FFFF;
    owners[2] = 32'hA5A5_5A5A; owners[3] = 32'h5A5A_A5A5;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, every command and strategy, exact fit, failures
    send(CmdReport, '0, '0, StratFirst, 0);
    send(CmdRequest, owners[0], 21'd0, StratFirst, 0);
    send(CmdRequest, owners[0], 21'd100, 2'd3, 0);
    send(CmdRequest, owners[0], 21'h1FFFFF, StratBest, 0);
    send(CmdRequest, owners[0], 21'd100, StratFirst, 0);
    send(CmdRequest, owners[1], 21'd50, StratBest, 0);
    send(CmdRequest, owners[2], 21'd100, StratWorst, 0);
    send(CmdRelease, owners[0], '0, StratFirst, 0);
    send(CmdRequest, owners[3], 21'd100, StratBest, 0);
    send(CmdRelease, 32'h1234_5678, '0, StratFirst, 0);
    send(CmdRelease, owners[1], '0, StratFirst, 0);
    send(CmdReport, '0, '0, StratFirst, 0);
    send(CmdCompact, '0, '0, StratFirst, 0);
    send(CmdReport, '0, '0, StratFirst, 0);
    send(CmdRequest, owners[1], 21'd1048376, StratFirst, 0);
    send(CmdCompact, '0, '0, StratFirst, 0);
    send(CmdRelease, owners[1], '0, StratFirst, 0);
    send(CmdRelease, owners[2], '0, StratFirst, 0);
    send(CmdRelease, owners[3], '0, StratFirst, 0);
    send(CmdCompact, '0, '0, StratFirst, 0);
    send(CmdReport, '0, '0, StratFirst, 0);

    // zero-size memory, then tiny memory filled with unit blocks to hit a full table
    set_total(21'd0);
    send(CmdReport, '0, '0, StratFirst, 0);
    send(CmdCompact, '0, '0, StratFirst, 0);
    send(CmdRequest, owners[0], 21'd1, StratFirst, 0);
    set_total(21'd40);
    for (int i = 0; i < 34; i++) send(CmdRequest, owners[i % 4], 21'd1, StratFirst, 1);
    send(CmdReport, '0, '0, StratFirst, 0);

    // random phases across sizes, receiver held off once mid-phase
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_total(21'h1FFFFF);
        1: set_total(21'd1);
        2: set_total(21'd64);
        3: set_total(21'd1000);
        default: set_total(21'h100000);
      endcase
      for (int i = 0; i < 80; i++) begin
        if (ph == 3 && i == 20) hold_long = 1;
        if (ph == 2 && i == 40) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        random_item(i >= 20 && i < 40);
      end
    end

    drain();
    if (fails == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #20000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

@@ files.f @@
hdl/cra_pkg.sv
hdl/cra_table.sv
hdl/cra_ctrl.sv
hdl/contiguous_region_allocator.sv
test/region_checker.sv
test/tb.sv
